### hdl/tmcw_pkg.sv
`default_nettype none
package tmcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int CELL_AW = $clog2(CELLS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int IDX_W   = 11;
	localparam int CMP_W   = ((CELL_AW > IDX_W) ? CELL_AW : IDX_W) + 1;

	localparam logic [2:0] CMD_PUT    = 3'd0;
	localparam logic [2:0] CMD_CLEAR  = 3'd1;
	localparam logic [2:0] CMD_SET_FG = 3'd2;
	localparam logic [2:0] CMD_RST_FG = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h0F;
	localparam logic [7:0] LEVEL_ON     = 8'd128;
	localparam logic [7:0] LEVEL_BRIGHT = 8'd200;

	typedef logic [CELL_AW-1:0] cell_addr_t;
	typedef logic [15:0]        cell_data_t;

	typedef struct packed {
		logic       we;
		cell_addr_t waddr;
		cell_data_t wdata;
		logic       re;
		cell_addr_t raddr;
	} mem_req_t;

	// 24-bit RGB -> 4-bit intensity color
	function automatic logic [3:0] fg_intensity(input logic [23:0] rgb);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [3:0] a;
		r = rgb[23:16];
		g = rgb[15:8];
		b = rgb[7:0];
		a[2] = (r > LEVEL_ON);
		a[1] = (g > LEVEL_ON);
		a[0] = (b > LEVEL_ON);
		a[3] = (r > LEVEL_BRIGHT) || (g > LEVEL_BRIGHT) || (b > LEVEL_BRIGHT);
		return a;
	endfunction

endpackage
`default_nettype wire

### hdl/tmcw_req_if.sv
`default_nettype none
interface tmcw_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [7:0]  char_code;
	logic [3:0]  clear_color;
	logic [23:0] fg_rgb;
	logic [10:0] cell_index;

	modport source (output valid, cmd, char_code, clear_color, fg_rgb, cell_index,
		input ready);
	modport sink (input valid, cmd, char_code, clear_color, fg_rgb, cell_index,
		output ready);
endinterface
`default_nettype wire

### hdl/tmcw_rsp_if.sv
`default_nettype none
interface tmcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_word;
	logic [10:0] cursor_pos;
	logic [7:0]  attr_now;

	modport source (output valid, cell_word, cursor_pos, attr_now, input ready);
	modport sink (input valid, cell_word, cursor_pos, attr_now, output ready);
endinterface
`default_nettype wire

### hdl/text_mode_console_writer.sv
`default_nettype none
// Text-mode console over an 80x25 store of 16-bit cells (attribute high byte,
// character low byte) held in one single-port-write, one-read synchronous RAM.
// One request in flight at a time; each request gives exactly one response.
// Color commands, and a newline, backspace or ordinary put that does not
// scroll, as well as reads out of range, pass through an execute state and a
// done state before the response is registered; a cell read adds a read state
// to capture the RAM data. A clear writes every cell, one per cycle. A put that
// scrolls copies the store one cell per cycle through the RAM and then blanks
// the bottom row. After reset a clearing pass writes zero to all COLUMNS*ROWS
// cells before the first request is taken.
// A response waiting in the output register does not block the next accept.
module text_mode_console_writer
	import tmcw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmcw_req_if.sink    req,
	tmcw_rsp_if.source  rsp
);

	mem_req_t   mreq;
	cell_data_t rdata;

	tmcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	tmcw_cell_ram u_ram (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

endmodule
`default_nettype wire

### hdl/tmcw_cell_ram.sv
`default_nettype none
module tmcw_cell_ram
	import tmcw_pkg::*;
(
	input  wire logic       clk,
	input  wire mem_req_t   mreq,
	output cell_data_t      rdata
);

	cell_data_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.re) begin
			rdata <= mem[mreq.raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/tmcw_ctrl.sv
`default_nettype none
module tmcw_ctrl
	import tmcw_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmcw_req_if.sink    req,
	tmcw_rsp_if.source  rsp,
	output mem_req_t    mreq,
	input  wire cell_data_t rdata
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [2:0]         cmd_q;
	logic [7:0]         char_q;
	logic [3:0]         color_q;
	logic [23:0]        rgb_q;
	logic [IDX_W-1:0]   idx_q;
	cell_addr_t         cursor_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [7:0]         attr_q;
	cell_addr_t         ptr_q;
	cell_data_t         fill_q;
	cell_data_t         word_q;
	logic               rd_s1;
	cell_addr_t         dst_s1;
	logic               res_valid_q;
	logic [15:0]        res_word_q;
	logic [10:0]        res_cursor_q;
	logic [7:0]         res_attr_q;

	logic       idx_ok;
	logic       col_last;
	logic       row_last;
	cell_addr_t row_base;
	cell_data_t blank;

	assign idx_ok   = CMP_W'(idx_q) < CMP_W'(CELLS);
	assign col_last = (col_q == COL_W'(COLUMNS - 1));
	assign row_last = (row_q == ROW_W'(ROWS - 1));
	assign row_base = cursor_q - cell_addr_t'(col_q);
	assign blank    = {attr_q, CH_SPACE};

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = res_valid_q;
	assign rsp.cell_word  = res_word_q;
	assign rsp.cursor_pos = res_cursor_q;
	assign rsp.attr_now   = res_attr_q;

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_INIT: begin
				mreq.we    = 1'b1;
				mreq.waddr = ptr_q;
				mreq.wdata = '0;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_PUT) begin
					if (char_q == CH_BACKSPACE) begin
						mreq.we    = (cursor_q != '0);
						mreq.waddr = cursor_q - cell_addr_t'(1);
						mreq.wdata = blank;
					end else if (char_q != CH_NEWLINE) begin
						mreq.we    = 1'b1;
						mreq.waddr = cursor_q;
						mreq.wdata = {attr_q, char_q};
					end
				end else if (cmd_q == CMD_READ) begin
					mreq.re    = idx_ok;
					mreq.raddr = cell_addr_t'(idx_q);
				end
			end
			ST_SCROLL: begin
				mreq.re    = 1'b1;
				mreq.raddr = ptr_q;
				mreq.we    = rd_s1;
				mreq.waddr = dst_s1;
				mreq.wdata = rdata;
			end
			ST_SCROLL_END: begin
				mreq.we    = rd_s1;
				mreq.waddr = dst_s1;
				mreq.wdata = rdata;
			end
			ST_FILL: begin
				mreq.we    = 1'b1;
				mreq.waddr = ptr_q;
				mreq.wdata = fill_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cmd_q        <= '0;
			char_q       <= '0;
			color_q      <= '0;
			rgb_q        <= '0;
			idx_q        <= '0;
			cursor_q     <= '0;
			col_q        <= '0;
			row_q        <= '0;
			attr_q       <= ATTR_RESET;
			ptr_q        <= '0;
			fill_q       <= '0;
			word_q       <= '0;
			rd_s1        <= 1'b0;
			dst_s1       <= '0;
			res_valid_q  <= 1'b0;
			res_word_q   <= '0;
			res_cursor_q <= '0;
			res_attr_q   <= '0;
		end else begin
			rd_s1  <= (state_q == ST_SCROLL);
			dst_s1 <= ptr_q - cell_addr_t'(COLUMNS);
			if (rsp.valid && rsp.ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				// clearing pass after reset
				ST_INIT: begin
					if (ptr_q == cell_addr_t'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + cell_addr_t'(1);
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						char_q  <= req.char_code;
						color_q <= req.clear_color;
						rgb_q   <= req.fg_rgb;
						idx_q   <= req.cell_index;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					word_q <= '0;
					case (cmd_q)
						CMD_PUT: begin
							if (char_q == CH_NEWLINE) begin
								col_q <= '0;
								if (row_last) begin
									cursor_q <= row_base;
									ptr_q    <= cell_addr_t'(COLUMNS);
									state_q  <= ST_SCROLL;
								end else begin
									cursor_q <= row_base + cell_addr_t'(COLUMNS);
									row_q    <= row_q + ROW_W'(1);
									state_q  <= ST_DONE;
								end
							end else if (char_q == CH_BACKSPACE) begin
								state_q <= ST_DONE;
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - cell_addr_t'(1);
									if (col_q == '0) begin
										col_q <= COL_W'(COLUMNS - 1);
										row_q <= row_q - ROW_W'(1);
									end else begin
										col_q <= col_q - COL_W'(1);
									end
								end
							end else if (col_last) begin
								col_q <= '0;
								if (row_last) begin
									cursor_q <= row_base;
									ptr_q    <= cell_addr_t'(COLUMNS);
									state_q  <= ST_SCROLL;
								end else begin
									cursor_q <= cursor_q + cell_addr_t'(1);
									row_q    <= row_q + ROW_W'(1);
									state_q  <= ST_DONE;
								end
							end else begin
								cursor_q <= cursor_q + cell_addr_t'(1);
								col_q    <= col_q + COL_W'(1);
								state_q  <= ST_DONE;
							end
						end
						CMD_CLEAR: begin
							attr_q   <= {color_q, 4'h0};
							fill_q   <= {color_q, 4'h0, CH_SPACE};
							cursor_q <= '0;
							col_q    <= '0;
							row_q    <= '0;
							ptr_q    <= '0;
							state_q  <= ST_FILL;
						end
						CMD_SET_FG: begin
							attr_q[3:0] <= fg_intensity(rgb_q);
							state_q     <= ST_DONE;
						end
						CMD_RST_FG: begin
							attr_q  <= ATTR_RESET;
							state_q <= ST_DONE;
						end
						CMD_READ: begin
							if (idx_ok) begin
								state_q <= ST_READ;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_READ: begin
					word_q  <= rdata;
					state_q <= ST_DONE;
				end
				// copy cell i+COLUMNS to i; write lands in the cycle after its read
				ST_SCROLL: begin
					if (ptr_q == cell_addr_t'(CELLS - 1)) begin
						state_q <= ST_SCROLL_END;
					end else begin
						ptr_q <= ptr_q + cell_addr_t'(1);
					end
				end
				ST_SCROLL_END: begin
					ptr_q   <= cell_addr_t'(CELLS - COLUMNS);
					fill_q  <= blank;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (ptr_q == cell_addr_t'(CELLS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + cell_addr_t'(1);
					end
				end
				ST_DONE: begin
					if (!res_valid_q || rsp.ready) begin
						res_valid_q  <= 1'b1;
						res_word_q   <= word_q;
						res_cursor_q <= 11'(cursor_q);
						res_attr_q   <= attr_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor_rowcol: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q == cell_addr_t'(int'(row_q) * COLUMNS + int'(col_q)))
		else $error("cursor does not match row/column");

	a_rowcol_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("row or column out of range");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");

	a_scroll_write_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && mreq.we) |-> (mreq.waddr < mreq.raddr))
		else $error("scroll write overtakes read");
`endif

endmodule
`default_nettype wire
